// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clock and reset names are fixed.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clk edge outside of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/rcsf_pkg.sv
// ----------------------------------------------------------------------------
// rcsf_pkg
// Types and constants for the radio stick filter and stick command detector.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsf_pkg;

  // Channel count and field widths
  localparam int NCHAN     = 4;
  localparam int PULSE_W   = 17;
  localparam int VALUE_W   = 16;
  localparam int CODE_W    = 2;
  localparam int PAT_W     = NCHAN * CODE_W;
  localparam int HOLD_W    = 4;
  localparam int ACC_W     = 24;
  // Internal signed width for raw, average and nudged values
  localparam int CALC_W    = 18;

  // Stream packing widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((NCHAN * PULSE_W + 7) / 8) * 8;
  localparam int OUT_BITS   = NCHAN * VALUE_W + PAT_W + 2 + 1 + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Divide by five: floor(x * 52429 / 2^18) is exact for any 17-bit x
  localparam int DIV5_MUL_W = 16;
  localparam int DIV5_SH    = 18;
  localparam int PROD_W     = PULSE_W + DIV5_MUL_W;
  localparam int QUO_W      = PROD_W - DIV5_SH;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 16'd52429;

  // Raw offset and hysteresis nudge
  localparam logic signed [CALC_W-1:0] RAW_OFFSET = 18'sd1200;
  localparam logic signed [CALC_W-1:0] NUDGE_BAND = 18'sd3;
  localparam logic signed [CALC_W-1:0] NUDGE_STEP = 18'sd2;

  // Stick codes within the pattern
  localparam logic [CODE_W-1:0] CODE_LOW  = 2'b01;
  localparam logic [CODE_W-1:0] CODE_HIGH = 2'b10;

  // Patterns that select a command
  localparam logic [PAT_W-1:0] PAT_ARM    = 8'h64;
  localparam logic [PAT_W-1:0] PAT_DISARM = 8'h54;
  localparam logic [PAT_W-1:0] PAT_CALIB  = 8'h50;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HIGH_THR   = 2'd0,
    REG_LOW_THR    = 2'd1,
    REG_HOLD_COUNT = 2'd2
  } reg_idx_t;

  // Stick command codes
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_CALIB  = 2'd3
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/rc_stick_filter_gesture.sv
// ----------------------------------------------------------------------------
// rc_stick_filter_gesture
// Low-pass filters four stick channels per frame, classes them high/low and
// fires arm, disarm or calibrate after a stick pattern is held.
// ----------------------------------------------------------------------------
//  Channel  Direction  Width  Contents
//  in_      slave      72     roll, pitch, yaw, throttle pulse (17 bits each)
//  out_     master     80     four values, pattern, command, locked, cal req
//  cfg_     write      16     high threshold, low threshold, hold count
//
//  One frame per cycle while out_ is not stalled: a frame is held in the input
//  register, then a single compute stage (divide-by-five multiply, filter
//  update, classing and command decode) loads the output register.
//  out_tvalid rises once the frame has passed the input register and the
//  output register has loaded its result.
//  rst_n is synchronous; filter, pattern, counter and lock state reset with it.
//  Stalls on out_ hold the output register; in_ keeps accepting while the
//  input register is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rc_stick_filter_gesture #(
  parameter int FILTER_SHIFT  = 4,
  parameter int CENTER_REST   = 500,
  parameter int THROTTLE_REST = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [16:0] roll_pulse, [33:17] pitch_pulse, [50:34] yaw_pulse,
  // [67:51] throttle_pulse, [71:68] zero
  input  wire logic [rcsf_pkg::IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [15:0] roll_value, [31:16] pitch_value, [47:32] yaw_value,
  // [63:48] throttle_value, [71:64] stick_pattern, [73:72] command,
  // [74] locked, [75] calibrate_request, [79:76] zero
  output logic [rcsf_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [rcsf_pkg::VALUE_W-1:0]    cfg_wdata
);

  import rcsf_pkg::*;

  // Filter rest values in accumulator scale
  localparam int ACC_CENTER_I   = CENTER_REST * (2 ** FILTER_SHIFT);
  localparam int ACC_THROTTLE_I = THROTTLE_REST * (2 ** FILTER_SHIFT);
  localparam logic signed [ACC_W-1:0] ACC_CENTER   = ACC_W'(ACC_CENTER_I);
  localparam logic signed [ACC_W-1:0] ACC_THROTTLE = ACC_W'(ACC_THROTTLE_I);

  // Configuration registers
  logic signed [VALUE_W-1:0] high_thr_r;
  logic signed [VALUE_W-1:0] low_thr_r;
  logic [HOLD_W-1:0]         hold_count_r;

  // Input register
  logic                      in_vld_r;
  logic [PULSE_W-1:0]        pulse_r [NCHAN];

  // Detector state
  logic signed [ACC_W-1:0]   acc_r   [NCHAN];
  logic signed [ACC_W-1:0]   acc_nxt [NCHAN];
  logic [PAT_W-1:0]          last_pat_r;
  logic [PAT_W-1:0]          last_pat_nxt;
  logic [HOLD_W-1:0]         rep_cnt_r;
  logic [HOLD_W-1:0]         rep_cnt_nxt;
  logic                      lock_r;
  logic                      lock_nxt;

  // Output register
  logic                      out_vld_r;
  logic signed [VALUE_W-1:0] val_r [NCHAN];
  logic [PAT_W-1:0]          pat_r;
  cmd_t                      cmd_r;
  logic                      locked_r;
  logic                      cal_req_r;

  // Compute stage results
  logic signed [CALC_W-1:0]  val_c [NCHAN];
  logic [PAT_W-1:0]          pat_c;
  cmd_t                      cmd_c;
  logic                      cal_req_c;

  logic                      advance;
  logic                      in_xfer;
  logic                      step;

  // Handshake: compute stage moves when the output register can take a result
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign step      = in_vld_r && advance;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r   <= 16'sd950;
      low_thr_r    <= 16'sd50;
      hold_count_r <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_THR:   high_thr_r   <= cfg_wdata;
        REG_LOW_THR:    low_thr_r    <= cfg_wdata;
        REG_HOLD_COUNT: hold_count_r <= cfg_wdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture pulses on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int c = 0; c < NCHAN; c++) begin
        pulse_r[c] <= in_tdata[c*PULSE_W +: PULSE_W];
      end
    end
  end

  // Per-channel filter: raw = pulse/5 - 1200, leaky average, hysteresis nudge
  always_comb begin
    logic [PROD_W-1:0]        prod;
    logic signed [CALC_W-1:0] raw;
    logic signed [CALC_W-1:0] avg;
    for (int c = 0; c < NCHAN; c++) begin
      prod = PROD_W'(pulse_r[c]) * PROD_W'(DIV5_MUL);
      raw  = $signed(CALC_W'(prod[PROD_W-1:DIV5_SH])) - RAW_OFFSET;
      avg  = CALC_W'(acc_r[c] >>> FILTER_SHIFT);
      acc_nxt[c] = acc_r[c] + ACC_W'(raw) - ACC_W'(avg);
      if (raw < avg - NUDGE_BAND) begin
        val_c[c] = avg - NUDGE_STEP;
      end else if (raw > avg + NUDGE_BAND) begin
        val_c[c] = avg + NUDGE_STEP;
      end else begin
        val_c[c] = avg;
      end
    end
  end

  // Class each value against the thresholds, roll in the low bits
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      pat_c[c*CODE_W +: CODE_W] =
        ((val_c[c] > CALC_W'(high_thr_r)) ? CODE_HIGH : '0) |
        ((val_c[c] < CALC_W'(low_thr_r))  ? CODE_LOW  : '0);
    end
  end

  // Pattern hold counter and command decode
  always_comb begin
    rep_cnt_nxt  = rep_cnt_r;
    lock_nxt     = lock_r;
    cmd_c        = CMD_NONE;
    cal_req_c    = 1'b0;
    last_pat_nxt = pat_c;
    if (pat_c != last_pat_r) begin
      rep_cnt_nxt = '0;
    end else if (rep_cnt_r < hold_count_r) begin
      rep_cnt_nxt = rep_cnt_r + 1'b1;
    end else begin
      rep_cnt_nxt = '0;
      case (last_pat_r)
        PAT_ARM: begin
          lock_nxt = 1'b0;
          cmd_c    = CMD_ARM;
        end
        PAT_DISARM: begin
          lock_nxt = 1'b1;
          cmd_c    = CMD_DISARM;
        end
        PAT_CALIB: begin
          cmd_c     = CMD_CALIB;
          cal_req_c = lock_r;
        end
        default: ;
      endcase
    end
  end

  // Detector state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCHAN - 1; c++) begin
        acc_r[c] <= ACC_CENTER;
      end
      acc_r[NCHAN-1] <= ACC_THROTTLE;
      last_pat_r <= '0;
      rep_cnt_r  <= '0;
      lock_r     <= 1'b1;
    end else if (step) begin
      for (int c = 0; c < NCHAN; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
      last_pat_r <= last_pat_nxt;
      rep_cnt_r  <= rep_cnt_nxt;
      lock_r     <= lock_nxt;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (step) begin
      for (int c = 0; c < NCHAN; c++) begin
        val_r[c] <= VALUE_W'(val_c[c]);
      end
      pat_r     <= pat_c;
      cmd_r     <= cmd_c;
      locked_r  <= lock_nxt;
      cal_req_r <= cal_req_c;
    end
  end

  // Pack the result stream
  always_comb begin
    out_tdata = '0;
    for (int c = 0; c < NCHAN; c++) begin
      out_tdata[c*VALUE_W +: VALUE_W] = val_r[c];
    end
    out_tdata[NCHAN*VALUE_W +: PAT_W]   = pat_r;
    out_tdata[NCHAN*VALUE_W + PAT_W +: 2] = cmd_r;
    out_tdata[NCHAN*VALUE_W + PAT_W + 2]  = locked_r;
    out_tdata[NCHAN*VALUE_W + PAT_W + 3]  = cal_req_r;
  end

  assign out_tvalid = out_vld_r;

  // A calibrate request only leaves with a calibrate command while locked
  `ASSERT_IMP(a_cal_req_cmd, out_vld_r && cal_req_r, (cmd_r == CMD_CALIB) && locked_r, "calibrate request without locked calibrate command")

  // An arm command unlocks in the cycle after it fires
  `ASSERT_CLK(a_arm_unlocks, (step && cmd_c == CMD_ARM) |=> !lock_r, "arm did not clear lock")

  // A full input register behind a stalled output must block new frames
  `ASSERT_IMP(a_stall_blocks, in_vld_r && out_vld_r && !out_tready, !in_tready, "input accepted while stage is full and output stalled")

endmodule

`default_nettype wire

// File: test/rc_stick_filter_gesture_test.sv
// ----------------------------------------------------------------------------
// rc_stick_filter_gesture_test
// Streams stick frames into the filter and command detector, predicts every
// report in a scoreboard and compares each output transfer field by field.
// Starts with a few directed frames (no capture, full scale, bit patterns,
// crossed thresholds). Then it runs phases of held stick gestures mixed with
// noise under several threshold and hold settings, with random idling on
// both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module rc_stick_filter_gesture_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsf_pkg::*;

  // Block parameters, mirrored by the scoreboard
  localparam int FILTER_SHIFT  = 4;
  localparam int CENTER_REST   = 500;
  localparam int THROTTLE_REST = 0;

  // Pulse to stick value conversion and hysteresis
  localparam int PULSE_SCALE  = 5;
  localparam int PULSE_CENTER = 1200;
  localparam int PULSE_MAX    = (1 << PULSE_W) - 1;
  localparam int BAND         = 3;
  localparam int STEP         = 2;

  // Register values after reset
  localparam int RESET_HIGH = 950;
  localparam int RESET_LOW  = 50;
  localparam int RESET_HOLD = 5;

  // Register index that selects nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [CODE_W-1:0] CODE_MID = 2'b00;

  localparam int MAX_SHOWN       = 10;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 20;

  // One frame of stick pulses, roll in the low bits
  typedef struct packed {
    logic [PULSE_W-1:0] throttle;
    logic [PULSE_W-1:0] yaw;
    logic [PULSE_W-1:0] pitch;
    logic [PULSE_W-1:0] roll;
  } frame_t;

  // One stick report, roll value in the low bits
  typedef struct packed {
    logic                      calib_req;
    logic                      locked;
    cmd_t                      command;
    logic [PAT_W-1:0]          pattern;
    logic signed [VALUE_W-1:0] throttle;
    logic signed [VALUE_W-1:0] yaw;
    logic signed [VALUE_W-1:0] pitch;
    logic signed [VALUE_W-1:0] roll;
  } stick_report_t;

  // Predicts the report for each accepted frame and checks the output
  class stick_scoreboard;
    int               high_thr;
    int               low_thr;
    int unsigned      hold_len;
    int               acc [NCHAN];
    logic [PAT_W-1:0] last_pat;
    int unsigned      repeats;
    logic             lock;
    stick_report_t    reports_due [$];
    int               mismatches;

    function new();
      high_thr = RESET_HIGH;
      low_thr  = RESET_LOW;
      hold_len = RESET_HOLD;
      for (int c = 0; c < NCHAN; c++) acc[c] = CENTER_REST << FILTER_SHIFT;
      acc[NCHAN-1] = THROTTLE_REST << FILTER_SHIFT;
      last_pat   = '0;
      repeats    = 0;
      lock       = 1'b1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [VALUE_W-1:0] val);
      case (idx)
        REG_HIGH_THR:   high_thr = int'($signed(val));
        REG_LOW_THR:    low_thr  = int'($signed(val));
        REG_HOLD_COUNT: hold_len = val[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_frame(frame_t f);
      int                pulse [NCHAN];
      int                level [NCHAN];
      int                raw;
      int                avg;
      logic [CODE_W-1:0] code;
      stick_report_t     r;
      pulse = '{int'(f.roll), int'(f.pitch), int'(f.yaw), int'(f.throttle)};
      r = '0;
      // Filter each channel and class the nudged value
      for (int c = 0; c < NCHAN; c++) begin
        raw = pulse[c] / PULSE_SCALE - PULSE_CENTER;
        avg = acc[c] >>> FILTER_SHIFT;
        acc[c] += raw - avg;
        if (raw < avg - BAND) level[c] = avg - STEP;
        else if (raw > avg + BAND) level[c] = avg + STEP;
        else level[c] = avg;
        code = CODE_MID;
        if (level[c] > high_thr) code |= CODE_HIGH;
        if (level[c] < low_thr) code |= CODE_LOW;
        r.pattern[CODE_W*c +: CODE_W] = code;
      end
      r.roll     = VALUE_W'(level[0]);
      r.pitch    = VALUE_W'(level[1]);
      r.yaw      = VALUE_W'(level[2]);
      r.throttle = VALUE_W'(level[3]);
      // Count repeats and decode the held pattern
      r.command = CMD_NONE;
      if (r.pattern == last_pat) begin
        if (repeats < hold_len) begin
          repeats++;
        end else begin
          repeats = 0;
          case (last_pat)
            PAT_ARM: begin
              lock = 1'b0;
              r.command = CMD_ARM;
            end
            PAT_DISARM: begin
              lock = 1'b1;
              r.command = CMD_DISARM;
            end
            PAT_CALIB: begin
              r.command   = CMD_CALIB;
              r.calib_req = lock;
            end
            default: ;
          endcase
        end
      end else begin
        repeats = 0;
      end
      last_pat = r.pattern;
      r.locked = lock;
      reports_due.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] d);
      stick_report_t got;
      stick_report_t want;
      got = stick_report_t'(d[OUT_BITS-1:0]);
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected report %h", d);
        return;
      end
      want = reports_due.pop_front();
      compare_field("roll_value", want.roll, got.roll);
      compare_field("pitch_value", want.pitch, got.pitch);
      compare_field("yaw_value", want.yaw, got.yaw);
      compare_field("throttle_value", want.throttle, got.throttle);
      compare_field("stick_pattern", want.pattern, got.pattern);
      compare_field("command", want.command, got.command);
      compare_field("locked", want.locked, got.locked);
      compare_field("calibrate_request", want.calib_req, got.calib_req);
      compare_field("padding", 0, d[OUT_DATA_W-1:OUT_BITS]);
    endfunction

    function int pending();
      return reports_due.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [1:0]            cfg_index  = '0;
  logic [VALUE_W-1:0]    cfg_wdata  = '0;

  stick_scoreboard sb = new();
  bit              idling       = 1'b1;
  bit              hold_off_req = 1'b0;
  int              frames_sent  = 0;
  int              idle_cycles  = 0;

  rc_stick_filter_gesture #(
    .FILTER_SHIFT (FILTER_SHIFT),
    .CENTER_REST  (CENTER_REST),
    .THROTTLE_REST(THROTTLE_REST)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one frame, with an optional gap first, and hold until transfer
  task automatic send_frame(input frame_t f);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(f);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_frame(f);
    frames_sent++;
  endtask

  // Stop offering and wait for every predicted report
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all registers back to back; optionally poke the unused index too
  task automatic program_regs(input logic [VALUE_W-1:0] high, input logic [VALUE_W-1:0] low,
                              input logic [VALUE_W-1:0] hold_word, input bit poke_unused);
    logic [1:0]         idx [4];
    logic [VALUE_W-1:0] val [4];
    idx = '{REG_HIGH_THR, REG_UNUSED, REG_LOW_THR, REG_HOLD_COUNT};
    val = '{high, VALUE_W'($urandom), low, hold_word};
    for (int i = 0; i < 4; i++) begin
      if (poke_unused || idx[i] != REG_UNUSED) begin
        cfg_we    <= 1'b1;
        cfg_index <= idx[i];
        cfg_wdata <= val[i];
        @(posedge clk);
        sb.write_reg(idx[i], val[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Pulse that lands on a stick value, clamped to the field
  function automatic logic [PULSE_W-1:0] pulse_for(input int level);
    int p;
    p = (level + PULSE_CENTER) * PULSE_SCALE + int'($urandom_range(0, PULSE_SCALE - 1));
    if (p < 0) p = 0;
    if (p > PULSE_MAX) p = PULSE_MAX;
    return PULSE_W'(p);
  endfunction

  // Hold the sticks in one pattern for a number of frames, with jitter
  task automatic hold_gesture(input logic [PAT_W-1:0] pat, input int len);
    int                 level [NCHAN];
    logic [PULSE_W-1:0] p [NCHAN];
    logic [CODE_W-1:0]  code;
    for (int c = 0; c < NCHAN; c++) begin
      code = pat[CODE_W*c +: CODE_W];
      if (code == CODE_HIGH) level[c] = sb.high_thr + int'($urandom_range(20, 1500));
      else if (code == CODE_LOW) level[c] = sb.low_thr - int'($urandom_range(20, 800));
      else level[c] = (sb.high_thr + sb.low_thr) / 2;
    end
    repeat (len) begin
      for (int c = 0; c < NCHAN; c++)
        p[c] = pulse_for(level[c] + int'($urandom_range(0, 12)) - 6);
      send_frame({p[3], p[2], p[1], p[0]});
    end
  endtask

  // One setting of the registers, then gestures mixed with noise
  task automatic run_phase(input int high, input int low, input int hold_word,
                           input int frames, input bit squeeze);
    int               stop_at;
    int               pick;
    logic [PAT_W-1:0] pat;
    drain_reports();
    program_regs(VALUE_W'(high), VALUE_W'(low), VALUE_W'(hold_word), 1'b0);
    if (squeeze) hold_off_req = 1'b1;
    stop_at = frames_sent + frames;
    while (frames_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise: any pulse, past the nominal range too
        send_frame({PULSE_W'($urandom), PULSE_W'($urandom),
                    PULSE_W'($urandom), PULSE_W'($urandom)});
      end else begin
        if (pick < 40) begin
          pat = PAT_ARM;
        end else if (pick < 58) begin
          pat = PAT_DISARM;
        end else if (pick < 80) begin
          pat = PAT_CALIB;
        end else begin
          for (int c = 0; c < NCHAN; c++) begin
            case ($urandom_range(0, 2))
              0: pat[CODE_W*c +: CODE_W] = CODE_MID;
              1: pat[CODE_W*c +: CODE_W] = CODE_LOW;
              default: pat[CODE_W*c +: CODE_W] = CODE_HIGH;
            endcase
          end
        end
        // some gestures are released before they can fire
        if ($urandom_range(0, 4) == 0) hold_gesture(pat, $urandom_range(2, 8));
        else hold_gesture(pat, $urandom_range(25, 70));
      end
    end
  endtask

  // Accept reports, stall in bursts, and honor one long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // End the run when nothing transfers for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int high;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no capture, full scale, nominal top, alternating bits, small pulses
    send_frame({4{PULSE_W'(0)}});
    send_frame({4{PULSE_W'(0)}});
    send_frame({4{PULSE_W'(PULSE_MAX)}});
    send_frame({4{PULSE_W'(100000)}});
    send_frame({17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555});
    send_frame({17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA});
    send_frame({17'd0, 17'd8500, 17'd8500, 17'd8500});
    send_frame({17'd9, 17'd6, 17'd5, 17'd4});

    // Crossed thresholds with zero hold: every channel both high and low
    drain_reports();
    program_regs(VALUE_W'(-1202), VALUE_W'(18802), VALUE_W'(0), 1'b1);
    repeat (4) send_frame({17'd0, 17'd8500, 17'd8500, 17'd8500});

    // Random phases over several settings, extremes included
    run_phase(RESET_HIGH, RESET_LOW, RESET_HOLD, 180, 1'b0);
    run_phase(18802, -1202, ($urandom_range(0, 4095) << HOLD_W) | 15, 180, 1'b0);
    run_phase(-1202, 18802, 0, 180, 1'b1);
    run_phase(2000, -600, 0, 180, 1'b0);
    run_phase(400, 300, 15, 180, 1'b0);
    high = int'($urandom_range(0, 3000)) - 500;
    run_phase(high, high - int'($urandom_range(50, 1500)), $urandom_range(0, 65535),
              180, 1'b0);
    // Last part runs at full rate on both sides
    idling = 1'b0;
    high = int'($urandom_range(0, 3000)) - 500;
    run_phase(high, high - int'($urandom_range(50, 1500)), $urandom_range(0, 15),
              180, 1'b0);

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/rcsf_pkg.sv
sv/rc_stick_filter_gesture.sv
test/rc_stick_filter_gesture_test.sv
